// ===== rtl/iia_pkg.sv =====
// ----------------------------------------------------------------------------
// iia_pkg
// Shared types and constants for the indexed insert/remove array.
// ----------------------------------------------------------------------------
package iia_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = 5;
    localparam int POS_W = 5;
    localparam int DATA_W = 32;
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_READ   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2
    } status_t;

    // Broadcast to every cell in the row
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [IDX_W-1:0] pos;
    } cmd_t;

endpackage

// ===== rtl/iia_cell.sv =====
// ----------------------------------------------------------------------------
// iia_cell
// One entry of the array; loads the new word, takes its left neighbour on an
// insert below it, or its right neighbour on a remove at or below it.
// ----------------------------------------------------------------------------
module iia_cell (
    input  logic                                 clk,
    input  logic [iia_pkg::IDX_W-1:0]            cell_idx,
    input  iia_pkg::cmd_t                        cmd,
    input  logic signed [iia_pkg::DATA_W-1:0]    value,
    input  logic signed [iia_pkg::DATA_W-1:0]    left_data,
    input  logic signed [iia_pkg::DATA_W-1:0]    right_data,
    output logic signed [iia_pkg::DATA_W-1:0]    data
);
    import iia_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.ins)
        begin
            if (cell_idx == cmd.pos)
            begin
                data_next = value;
            end
            else if (cell_idx > cmd.pos)
            begin
                data_next = left_data;
            end
        end
        else if (cmd.rem && (cell_idx >= cmd.pos))
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/indexed_insert_remove_array.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_remove_array
// Bounded ordered array of signed words with insert, remove and read by index.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with mode, position and value; a word is taken at any edge
//   where start is high and busy is low. busy stays low, so a new word may
//   be issued every cycle.
//   In the cycle after a word is taken, done is high for exactly one cycle with
//   status, count (length after the operation) and read_value.
//   Throughput is one word per cycle: the row of cells shifts every later
//   entry in the same cycle as the insert or remove, and a read is a single
//   selection across the row.
//   cfg_wr_en / cfg_wr_data set capacity_limit; write it only while idle.
//   The effective capacity is the smaller of capacity_limit and the depth.
//   Reset clears the length to zero and sets the capacity to 16; the entry
//   cells are not cleared, as only entries below the length are ever read.
//   The receiver cannot hold results off: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
module indexed_insert_remove_array (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           mode,
    input  logic [iia_pkg::POS_W-1:0]            position,
    input  logic signed [iia_pkg::DATA_W-1:0]    value,
    output logic                                 done,
    output logic [1:0]                           status,
    output logic [iia_pkg::CNT_W-1:0]            count,
    output logic signed [iia_pkg::DATA_W-1:0]    read_value,
    input  logic                                 cfg_wr_en,
    input  logic [iia_pkg::CNT_W-1:0]            cfg_wr_data
);
    import iia_pkg::*;

    logic [CNT_W-1:0]         cap_reg;
    logic [CNT_W-1:0]         used_reg;
    logic [CNT_W-1:0]         used_next;
    logic                     done_reg;
    status_t                  status_reg;
    status_t                  status_next;
    logic [CNT_W-1:0]         count_reg;
    logic signed [DATA_W-1:0] rd_reg;
    logic signed [DATA_W-1:0] rd_next;
    logic [CNT_W-1:0]         eff_cap;
    logic                     accept;
    cmd_t                     cmd;
    logic [IDX_W-1:0]         pos_idx;
    logic signed [DATA_W-1:0] cell_data [DEPTH];

    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign eff_cap = (cap_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_reg;
    // only used once the position is known to lie inside the row
    assign pos_idx = position[IDX_W-1:0];

    always_comb
    begin
        status_next = ST_DONE;
        used_next   = used_reg;
        rd_next     = '0;
        cmd.ins     = 1'b0;
        cmd.rem     = 1'b0;
        cmd.pos     = pos_idx;
        unique case (mode)
            MODE_INSERT:
            begin
                if (used_reg >= eff_cap)
                begin
                    status_next = ST_FULL;
                end
                else if (position > used_reg)
                begin
                    status_next = ST_BADPOS;
                end
                else
                begin
                    cmd.ins   = accept;
                    used_next = used_reg + CNT_W'(1);
                end
            end
            MODE_REMOVE:
            begin
                if (position >= used_reg)
                begin
                    status_next = ST_BADPOS;
                end
                else
                begin
                    cmd.rem   = accept;
                    used_next = used_reg - CNT_W'(1);
                end
            end
            MODE_READ:
            begin
                if (position >= used_reg)
                begin
                    status_next = ST_BADPOS;
                end
                else
                begin
                    rd_next = cell_data[pos_idx];
                end
            end
            default:
            begin
                status_next = ST_BADPOS;
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_w;
            logic signed [DATA_W-1:0] right_w;
            if (i == 0)
            begin : g_first
                assign left_w = cell_data[i];
            end
            else
            begin : g_mid_l
                assign left_w = cell_data[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_last
                assign right_w = cell_data[i];
            end
            else
            begin : g_mid_r
                assign right_w = cell_data[i+1];
            end
            iia_cell u_cell (
                .clk        (clk),
                .cell_idx   (IDX_W'(i)),
                .cmd        (cmd),
                .value      (value),
                .left_data  (left_w),
                .right_data (right_w),
                .data       (cell_data[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CAP_RESET;
            used_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                used_reg <= used_next;
            end
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            count_reg  <= used_next;
            rd_reg     <= rd_next;
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign count      = count_reg;
    assign read_value = rd_reg;

endmodule
